>>> rtl/core/yrq_pkg.sv
// Shared types, widths and constants for the YUV pair to RGB quantizer.
package yrq_pkg;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 2;
   localparam int TABLE_DEPTH = 256;
   localparam int CHROMA_W    = 9;
   localparam int PROD_W      = 20;
   localparam int FRAC_BITS   = 10;
   localparam int DELTA_W     = PROD_W - FRAC_BITS;
   localparam int SUM_W       = 11;

   localparam logic signed [PROD_W-1:0] COEF_RV = PROD_W'(1436);
   localparam logic signed [PROD_W-1:0] COEF_GU = PROD_W'(352);
   localparam logic signed [PROD_W-1:0] COEF_GV = PROD_W'(731);
   localparam logic signed [PROD_W-1:0] COEF_BU = PROD_W'(1815);
   localparam logic [BYTE_W-1:0]        CHROMA_OFFSET = BYTE_W'(128);

   typedef enum logic {
      OP_TABLE_WRITE = 1'b0,
      OP_PIXEL_PAIR  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type        op;
      logic [BYTE_W-1:0] table_index;
      logic [BYTE_W-1:0] table_entry;
      logic [BYTE_W-1:0] luma_first;
      logic [BYTE_W-1:0] luma_second;
      logic              two_pix;
   } item_type;

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic [SUM_W-1:0] s);
      logic [BYTE_W-1:0] r;
      priority if (s[SUM_W-1]) begin
         r = '0;
      end else if (s[SUM_W-2:BYTE_W] != '0) begin
         r = '1;
      end else begin
         r = s[BYTE_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/yrq_req_if.sv
// Request channel interface: table writes and pixel pair transactions.
interface yrq_req_if import yrq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [BYTE_W-1:0]  table_index;
   logic [BYTE_W-1:0]  table_entry;
   logic [BYTE_W-1:0]  luma_first;
   logic [BYTE_W-1:0]  luma_second;
   logic [BYTE_W-1:0]  chroma_blue;
   logic [BYTE_W-1:0]  chroma_red;
   logic [COUNT_W-1:0] pixel_count;

   modport source (
      output valid, opcode, table_index, table_entry, luma_first, luma_second,
             chroma_blue, chroma_red, pixel_count,
      input  ready
   );

   modport sink (
      input  valid, opcode, table_index, table_entry, luma_first, luma_second,
             chroma_blue, chroma_red, pixel_count,
      output ready
   );
endinterface

>>> rtl/core/yrq_rsp_if.sv
// Response channel interface: one quantized RGB pixel per transaction.
interface yrq_rsp_if import yrq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] channel_first;
   logic [BYTE_W-1:0] channel_middle;
   logic [BYTE_W-1:0] channel_third;
   logic              last_of_run;

   modport source (
      output valid, channel_first, channel_middle, channel_third, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, channel_first, channel_middle, channel_third, last_of_run,
      output ready
   );
endinterface

>>> rtl/core/yrq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module yrq_ram import yrq_pkg::*; #(
   parameter  int WIDTH  = BYTE_W,
   parameter  int DEPTH  = TABLE_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/yuv420_pair_to_rgb_quantize.sv
// Top level: BT.601 YUV pixel pair to quantized RGB converter.
//
// Usage: the req channel carries two kinds of transaction. A table write
// (opcode 0) stores table_entry at table_index of the quantization table and
// produces no response. A pixel pair (opcode 1) produces one response per
// pixel (pixel_count 1 or 2, 3 acts as 2, 0 produces nothing); last_of_run
// marks the final pixel. csr_wr_data sets the R/B swap, written while idle.
//
// Pipeline: input register, chroma multipliers, chroma term adders, then a
// pixel serializer that clamps and reads three table copies whose registered
// read data is the response register. A second pixel follows the first once
// the response register can take it. Throughput: one response per cycle
// while rsp.ready is high; the serializer stage sets that rate and holds a
// pair until both its pixels are sent.
// Reset clears the valid bits and the swap bit; table contents stay undefined
// until written. When rsp.ready is low the response holds and the stages fill
// behind it; req.ready drops only once all stages but the response are full.
module yuv420_pair_to_rgb_quantize import yrq_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     csr_wr_en,
   input logic     csr_wr_data,
   yrq_req_if.sink   req,
   yrq_rsp_if.source rsp
);

   logic swap_ff, swap_in;

   logic              a_valid_ff, a_valid_in, a_ready, a_keep;
   item_type          a_item_ff, a_item_in;
   logic [BYTE_W-1:0] a_cb_ff, a_cb_in, a_cr_ff, a_cr_in;

   logic                     b_valid_ff, b_valid_in, b_ready;
   item_type                 b_item_ff;
   logic signed [PROD_W-1:0] b_rv_ff, b_gu_ff, b_gv_ff, b_bu_ff;
   logic signed [PROD_W-1:0] b_rv_in, b_gu_in, b_gv_in, b_bu_in;

   logic                      c_valid_ff, c_valid_in, c_ready;
   item_type                  c_item_ff;
   logic signed [DELTA_W-1:0] c_dr_ff, c_dg_ff, c_db_ff, c_dr_in, c_dg_in, c_db_in;
   logic                      sel_ff, sel_in;

   logic d_valid_ff, d_valid_in, d_last_ff, d_last_in, d_ready;

   logic signed [CHROMA_W-1:0] cu, cv;
   logic signed [PROD_W-1:0]   cu_ext, cv_ext;
   logic [DELTA_W:0]           dg_wide;
   logic                       c_is_write, c_last, c_emit, c_done;
   logic [BYTE_W-1:0]          luma;
   logic [SUM_W-1:0]           sum_r, sum_g, sum_b;
   logic [BYTE_W-1:0]          addr_r, addr_g, addr_b, q_r, q_g, q_b;
   logic                       ram_wr;

   assign swap_in = csr_wr_en ? csr_wr_data : swap_ff;

   // input stage
   assign a_ready   = !a_valid_ff || b_ready;
   assign req.ready = a_ready;
   assign a_keep    = (req.opcode == OP_TABLE_WRITE) || (req.pixel_count != '0);

   always_comb begin
      a_valid_in = a_valid_ff;
      a_item_in  = a_item_ff;
      a_cb_in    = a_cb_ff;
      a_cr_in    = a_cr_ff;
      if (a_ready) begin
         a_valid_in = req.valid && a_keep;
         a_item_in.op          = opcode_type'(req.opcode);
         a_item_in.table_index = req.table_index;
         a_item_in.table_entry = req.table_entry;
         a_item_in.luma_first  = req.luma_first;
         a_item_in.luma_second = req.luma_second;
         a_item_in.two_pix     = req.pixel_count[COUNT_W-1];
         a_cb_in = req.chroma_blue;
         a_cr_in = req.chroma_red;
      end
   end

   // multiply stage
   assign cu     = {1'b0, a_cb_ff} - {1'b0, CHROMA_OFFSET};
   assign cv     = {1'b0, a_cr_ff} - {1'b0, CHROMA_OFFSET};
   assign cu_ext = {{(PROD_W-CHROMA_W){cu[CHROMA_W-1]}}, cu};
   assign cv_ext = {{(PROD_W-CHROMA_W){cv[CHROMA_W-1]}}, cv};
   assign b_rv_in = cv_ext * COEF_RV;
   assign b_gu_in = cu_ext * COEF_GU;
   assign b_gv_in = cv_ext * COEF_GV;
   assign b_bu_in = cu_ext * COEF_BU;

   assign b_ready    = !b_valid_ff || c_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   // chroma term stage: floor shift is the upper product bits
   assign dg_wide = - {b_gu_ff[PROD_W-1], b_gu_ff[PROD_W-1:FRAC_BITS]}
                    - {b_gv_ff[PROD_W-1], b_gv_ff[PROD_W-1:FRAC_BITS]};
   assign c_dr_in = b_rv_ff[PROD_W-1:FRAC_BITS];
   assign c_db_in = b_bu_ff[PROD_W-1:FRAC_BITS];
   assign c_dg_in = dg_wide[DELTA_W-1:0];

   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   // serializer stage
   assign c_is_write = c_item_ff.op == OP_TABLE_WRITE;
   assign c_last     = !c_item_ff.two_pix || sel_ff;
   assign d_ready    = !d_valid_ff || rsp.ready;
   assign c_emit     = c_valid_ff && !c_is_write && d_ready;
   assign c_done     = c_valid_ff && (c_is_write || (d_ready && c_last));
   assign c_ready    = !c_valid_ff || c_done;
   assign sel_in     = c_emit ? !c_last : sel_ff;
   assign ram_wr     = c_valid_ff && c_is_write;

   assign luma  = sel_ff ? c_item_ff.luma_second : c_item_ff.luma_first;
   assign sum_r = {{(SUM_W-BYTE_W){1'b0}}, luma}
                  + {{(SUM_W-DELTA_W){c_dr_ff[DELTA_W-1]}}, c_dr_ff};
   assign sum_g = {{(SUM_W-BYTE_W){1'b0}}, luma}
                  + {{(SUM_W-DELTA_W){c_dg_ff[DELTA_W-1]}}, c_dg_ff};
   assign sum_b = {{(SUM_W-BYTE_W){1'b0}}, luma}
                  + {{(SUM_W-DELTA_W){c_db_ff[DELTA_W-1]}}, c_db_ff};
   assign addr_r = clamp_byte(sum_r);
   assign addr_g = clamp_byte(sum_g);
   assign addr_b = clamp_byte(sum_b);

   assign d_valid_in = d_ready ? c_emit : d_valid_ff;
   assign d_last_in  = c_emit ? c_last : d_last_ff;

   yrq_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram_r (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (c_item_ff.table_index),
      .wr_data (c_item_ff.table_entry),
      .rd_en   (c_emit),
      .rd_addr (addr_r),
      .rd_data (q_r)
   );

   yrq_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram_g (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (c_item_ff.table_index),
      .wr_data (c_item_ff.table_entry),
      .rd_en   (c_emit),
      .rd_addr (addr_g),
      .rd_data (q_g)
   );

   yrq_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (c_item_ff.table_index),
      .wr_data (c_item_ff.table_entry),
      .rd_en   (c_emit),
      .rd_addr (addr_b),
      .rd_data (q_b)
   );

   assign rsp.valid          = d_valid_ff;
   assign rsp.channel_first  = swap_ff ? q_b : q_r;
   assign rsp.channel_middle = q_g;
   assign rsp.channel_third  = swap_ff ? q_r : q_b;
   assign rsp.last_of_run    = d_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff    <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         sel_ff     <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         swap_ff    <= swap_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         sel_ff     <= sel_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
      a_cb_ff   <= a_cb_in;
      a_cr_ff   <= a_cr_in;
      d_last_ff <= d_last_in;
      if (b_ready) begin
         b_item_ff <= a_item_ff;
         b_rv_ff   <= b_rv_in;
         b_gu_ff   <= b_gu_in;
         b_gv_ff   <= b_gv_in;
         b_bu_ff   <= b_bu_in;
      end
      if (c_ready) begin
         c_item_ff <= b_item_ff;
         c_dr_ff   <= c_dr_in;
         c_dg_ff   <= c_dg_in;
         c_db_ff   <= c_db_in;
      end
   end

endmodule

>>> rtl/core/yrq_checker.sv
// Port-level checker for the YUV pair to RGB quantizer, bound to the top level.
module yrq_checker import yrq_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_channel_first,
   input logic [BYTE_W-1:0] rsp_channel_middle,
   input logic [BYTE_W-1:0] rsp_channel_third,
   input logic              rsp_last_of_run
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // second pixel of a pair follows its first at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("second pixel of pair missing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_channel_first) && $stable(rsp_channel_middle)
         && $stable(rsp_channel_third) && $stable(rsp_last_of_run))
      else $error("response changed while stalled");

endmodule

bind yuv420_pair_to_rgb_quantize yrq_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_channel_first  (rsp.channel_first),
   .rsp_channel_middle (rsp.channel_middle),
   .rsp_channel_third  (rsp.channel_third),
   .rsp_last_of_run    (rsp.last_of_run)
);

>>> dv/tb_top.sv
// Testbench for yuv420_pair_to_rgb_quantize: random and directed YUV pair traffic, self-checked.
module tb_top;
   import yrq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int K_RED_V      = 1436;
   localparam int K_GREEN_U    = 352;
   localparam int K_GREEN_V    = 731;
   localparam int K_BLUE_U     = 1815;
   localparam int CHROMA_MID   = 128;
   localparam int FRAC_SHIFT   = 10;
   localparam int GAP_MAX      = 17;
   localparam int QUIET_CYCLES = 10;
   localparam int HOLD_CYCLES  = 160;
   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 1300;

   typedef struct packed {
      opcode_type         op;
      logic [BYTE_W-1:0]  tbl_index;
      logic [BYTE_W-1:0]  tbl_entry;
      logic [BYTE_W-1:0]  y0;
      logic [BYTE_W-1:0]  y1;
      logic [BYTE_W-1:0]  u;
      logic [BYTE_W-1:0]  v;
      logic [COUNT_W-1:0] count;
   } yuv_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ch_first;
      logic [BYTE_W-1:0] ch_middle;
      logic [BYTE_W-1:0] ch_third;
      logic              last;
   } pixel_rgb_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   yrq_req_if req_ch ();
   yrq_rsp_if rsp_ch ();

   yuv420_pair_to_rgb_quantize dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   logic [BYTE_W-1:0] quant_shadow [TABLE_DEPTH];
   logic              swap_shadow;
   pixel_rgb_type     rgb_expected_q [$];

   int unsigned req_gap_max  = 0;
   int unsigned rsp_wait_max = 0;
   int unsigned rsp_wait_left;
   logic        rsp_hold = 1'b0;
   int unsigned idle_cycles;

   int unsigned n_errors;
   int unsigned n_table_writes;
   int unsigned n_pixel_items;
   int unsigned n_results;
   bit          swap_seen [2];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] clip_to_byte(input int s);
      if (s < 0) return '0;
      if (s > 255) return '1;
      return s[BYTE_W-1:0];
   endfunction

   task automatic predict_pair(input yuv_item_type it);
      int npix, cu, cv, d_red, d_green, d_blue, y;
      logic [BYTE_W-1:0] q_red, q_green, q_blue;
      pixel_rgb_type px;
      npix = (it.count > 2'd2) ? 2 : int'(it.count);
      cu = int'(it.u) - CHROMA_MID;
      cv = int'(it.v) - CHROMA_MID;
      d_red = (K_RED_V * cv) >>> FRAC_SHIFT;
      d_green = -((K_GREEN_U * cu) >>> FRAC_SHIFT) - ((K_GREEN_V * cv) >>> FRAC_SHIFT);
      d_blue = (K_BLUE_U * cu) >>> FRAC_SHIFT;
      for (int k = 0; k < npix; k++) begin
         y = (k == 0) ? int'(it.y0) : int'(it.y1);
         q_red   = quant_shadow[clip_to_byte(y + d_red)];
         q_green = quant_shadow[clip_to_byte(y + d_green)];
         q_blue  = quant_shadow[clip_to_byte(y + d_blue)];
         px.ch_first  = swap_shadow ? q_blue : q_red;
         px.ch_middle = q_green;
         px.ch_third  = swap_shadow ? q_red : q_blue;
         px.last      = (k == npix - 1);
         rgb_expected_q.push_back(px);
      end
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         n_errors++;
      end
   endtask

   // Score results first, then predict newly accepted transactions.
   always @(posedge clock) begin : scoreboard
      yuv_item_type  it;
      pixel_rgb_type got, want;
      if (reset) begin
         swap_shadow = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.channel_first, rsp_ch.channel_middle, rsp_ch.channel_third,
                    rsp_ch.last_of_run};
            n_results++;
            if (rgb_expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, got);
               n_errors++;
            end else begin
               want = rgb_expected_q.pop_front();
               check_field("channel_first", want.ch_first, got.ch_first);
               check_field("channel_middle", want.ch_middle, got.ch_middle);
               check_field("channel_third", want.ch_third, got.ch_third);
               check_field("last_of_run", BYTE_W'(want.last), BYTE_W'(got.last));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            it = '{opcode_type'(req_ch.opcode), req_ch.table_index, req_ch.table_entry,
                   req_ch.luma_first, req_ch.luma_second, req_ch.chroma_blue,
                   req_ch.chroma_red, req_ch.pixel_count};
            if (it.op == OP_TABLE_WRITE) begin
               quant_shadow[it.tbl_index] = it.tbl_entry;
               n_table_writes++;
            end else begin
               predict_pair(it);
               n_pixel_items++;
               swap_seen[swap_shadow] = 1'b1;
            end
         end
         if (csr_wr_en) swap_shadow = csr_wr_data;
      end
   end

   always @(posedge clock) begin : rsp_ready_driver
      int unsigned w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait_left <= 0;
      end else if (rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         w = $urandom_range(0, rsp_wait_max);
         rsp_wait_left <= w;
         rsp_ch.ready <= (w == 0);
      end else if (rsp_wait_left > 1) begin
         rsp_wait_left <= rsp_wait_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_wait_left <= 0;
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input yuv_item_type it);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= it.op;
      req_ch.table_index <= it.tbl_index;
      req_ch.table_entry <= it.tbl_entry;
      req_ch.luma_first  <= it.y0;
      req_ch.luma_second <= it.y1;
      req_ch.chroma_blue <= it.u;
      req_ch.chroma_red  <= it.v;
      req_ch.pixel_count <= it.count;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid, wait for every expected result, then let the pipeline go quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rgb_expected_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_swap(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic yuv_item_type pixel_item(input logic [7:0] y0, y1, u, v,
                                               input logic [1:0] count);
      yuv_item_type it;
      it = '{OP_PIXEL_PAIR, 8'($urandom), 8'($urandom), y0, y1, u, v, count};
      return it;
   endfunction

   function automatic yuv_item_type table_item(input logic [7:0] index, entry);
      yuv_item_type it;
      it = '{OP_TABLE_WRITE, index, entry, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 2'($urandom)};
      return it;
   endfunction

   function automatic yuv_item_type random_item();
      yuv_item_type it;
      int unsigned  pick;
      it = table_item(8'($urandom), 8'($urandom));
      if ($urandom_range(0, 99) < 15) return it;
      it.op = OP_PIXEL_PAIR;
      pick = $urandom_range(0, 9);
      it.count = (pick == 0) ? 2'd0 : (pick <= 3) ? 2'd1 : (pick <= 8) ? 2'd2 : 2'd3;
      return it;
   endfunction

   task automatic test_table_load();
      for (int i = 0; i < TABLE_DEPTH; i++) send_item(table_item(8'(i), 8'($urandom)));
   endtask

   task automatic test_directed_pixels();
      send_item(pixel_item(8'd0, 8'd0, 8'd0, 8'd0, 2'd2));
      send_item(pixel_item(8'd255, 8'd255, 8'd255, 8'd255, 2'd2));
      send_item(pixel_item(8'd0, 8'd255, 8'd0, 8'd255, 2'd2));
      send_item(pixel_item(8'd255, 8'd0, 8'd255, 8'd0, 2'd2));
      send_item(pixel_item(8'd0, 8'd255, 8'd128, 8'd128, 2'd2));
      send_item(pixel_item(8'd128, 8'd128, 8'd128, 8'd128, 2'd1));
      send_item(pixel_item(8'd40, 8'd200, 8'd127, 8'd129, 2'd1));
      send_item(pixel_item(8'd17, 8'd200, 8'd90, 8'd180, 2'd3));
      send_item(pixel_item(8'd99, 8'd99, 8'd60, 8'd60, 2'd0));
      send_item(table_item(8'd0, 8'd255));
      send_item(table_item(8'd255, 8'd0));
      send_item(pixel_item(8'd0, 8'd255, 8'd128, 8'd128, 2'd2));
      send_item(pixel_item(8'd10, 8'd245, 8'd0, 8'd255, 2'd3));
   endtask

   task automatic test_channel_swap();
      settle();
      write_swap(1'b1);
      send_item(pixel_item(8'd0, 8'd255, 8'd0, 8'd255, 2'd2));
      send_item(pixel_item(8'd255, 8'd0, 8'd255, 8'd0, 2'd1));
      send_item(pixel_item(8'd128, 8'd64, 8'd200, 8'd30, 2'd3));
      send_item(pixel_item(8'd1, 8'd2, 8'd3, 8'd4, 2'd0));
      settle();
      write_swap(1'b0);
   endtask

   task automatic test_backpressure();
      yuv_item_type it;
      req_gap_max  = 0;
      rsp_wait_max = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 40; i++) begin
         it = random_item();
         it.op = OP_PIXEL_PAIR;
         send_item(it);
      end
      settle();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      yuv_item_type it;
      int unsigned  useful, per_phase;
      per_phase = n_items / 6;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         write_swap(phase[0]);
         useful = 0;
         while (useful < per_phase) begin
            if (useful % 48 == 0) begin
               req_gap_max  = $urandom_range(0, 1) * GAP_MAX;
               rsp_wait_max = $urandom_range(0, 1) * GAP_MAX;
            end
            it = random_item();
            send_item(it);
            if (it.op == OP_TABLE_WRITE || it.count != 2'd0) useful++;
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_TABLE_WRITE;
      req_ch.table_index <= '0;
      req_ch.table_entry <= '0;
      req_ch.luma_first  <= '0;
      req_ch.luma_second <= '0;
      req_ch.chroma_blue <= '0;
      req_ch.chroma_red  <= '0;
      req_ch.pixel_count <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_table_load();
      test_directed_pixels();
      test_channel_swap();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);
      settle();

      if (rgb_expected_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, rgb_expected_q.size());
         n_errors += rgb_expected_q.size();
      end
      $display("covered %0d table writes and %0d pixel transactions, %0d results checked",
               n_table_writes, n_pixel_items, n_results);
      $display("both channel orders used: %0d, one long receiver hold-off, gaps 0..%0d",
               swap_seen[0] && swap_seen[1], GAP_MAX);
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
